// ----- sv/tpa_pkg.sv -----
`timescale 1ns / 1ps
package tpa_pkg;
  localparam int MAX_NODES = 1024;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int NODE_W    = 11;
  localparam int VAL_W     = 32;
  localparam int POS_W     = NODE_W + 1;
  localparam int OP_W      = 3;

  localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_INC   = 3'd1;
  localparam logic [OP_W-1:0] OP_DEC   = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  typedef struct packed {
    logic [NODE_W-1:0] top;
    logic [NODE_W-1:0] depth;
    logic [NODE_W-1:0] parent;
    logic [NODE_W-1:0] position;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [VAL_W-1:0]  amount;
    entry_t            entry;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [VAL_W-1:0]  value;
  } res_t;

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    return (n != '0) && (n <= NODE_W'(MAX_NODES));
  endfunction

  function automatic logic [ADDR_W-1:0] node_addr(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] d;
    d = n - NODE_W'(1);
    return d[ADDR_W-1:0];
  endfunction
endpackage

// ----- sv/tpa_ram.sv -----
`timescale 1ns / 1ps
module tpa_ram #(
  parameter int W  = 32,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/tpa_seq.sv -----
`timescale 1ns / 1ps
module tpa_seq import tpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  item_t             item,
  input  logic [NODE_W-1:0] node_count,
  input  logic              out_free,
  output logic              ready,
  output logic              res_valid,
  output res_t              res
);
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_RX    = 5'd2;
  localparam logic [4:0] S_RY    = 5'd3;
  localparam logic [4:0] S_GFY   = 5'd4;
  localparam logic [4:0] S_CHK   = 5'd5;
  localparam logic [4:0] S_RFY   = 5'd6;
  localparam logic [4:0] S_SEL   = 5'd7;
  localparam logic [4:0] S_RX2   = 5'd8;
  localparam logic [4:0] S_ADD2  = 5'd9;
  localparam logic [4:0] S_PAR   = 5'd10;
  localparam logic [4:0] S_TOP   = 5'd11;
  localparam logic [4:0] S_FX    = 5'd12;
  localparam logic [4:0] S_FY    = 5'd13;
  localparam logic [4:0] S_FSEL  = 5'd14;
  localparam logic [4:0] S_FLAST = 5'd15;
  localparam logic [4:0] S_FRD   = 5'd16;
  localparam logic [4:0] S_FWR   = 5'd17;
  localparam logic [4:0] S_QT    = 5'd18;
  localparam logic [4:0] S_QP    = 5'd19;
  localparam logic [4:0] S_SRD   = 5'd20;
  localparam logic [4:0] S_SACC  = 5'd21;
  localparam logic [4:0] S_DONE  = 5'd22;

  logic [4:0]        state, ret;
  logic [NODE_W-1:0] x, y, fx, fy, steps, cpar;
  logic [NODE_W-1:0] cp;
  entry_t            e1;
  logic [VAL_W-1:0]  z, fv, sum;
  logic [POS_W-1:0]  fp, lb, lim;
  logic [ADDR_W-1:0] clr_cnt;

  logic [NODE_W-1:0]  tbl_rnode;
  logic               ok_q;
  logic [ENTRY_W-1:0] tbl_rdata;
  entry_t             ent;
  logic               tbl_we;

  logic               fen_we;
  logic [ADDR_W-1:0]  fen_waddr, fen_raddr;
  logic [VAL_W-1:0]   fen_wdata, fen_rdata;
  logic [POS_W-1:0]   fpm1, qpos;
  logic               fp_in;

  assign ready  = (state == S_IDLE);
  assign ent    = ok_q ? entry_t'(tbl_rdata) : '0;
  assign lim    = (node_count > NODE_W'(MAX_NODES)) ? POS_W'(MAX_NODES) : POS_W'(node_count);
  assign lb     = fp & (~fp + POS_W'(1));
  assign fpm1   = fp - POS_W'(1);
  assign fp_in  = (fp != '0) && (fp <= lim);
  assign qpos   = (ent.position > NODE_W'(MAX_NODES)) ? POS_W'(MAX_NODES)
                                                      : POS_W'(ent.position);
  assign tbl_we = start && (item.op == OP_LOAD) && node_ok(item.node_a);

  always_comb begin
    unique case (state)
      S_RX, S_RX2, S_FX, S_QT: tbl_rnode = x;
      S_RY, S_FY:              tbl_rnode = y;
      S_CHK:                   tbl_rnode = fx;
      S_RFY:                   tbl_rnode = fy;
      S_PAR:                   tbl_rnode = cpar;
      default:                 tbl_rnode = x;
    endcase
  end

  always_comb begin
    fen_raddr = fpm1[ADDR_W-1:0];
    fen_we    = (state == S_CLR) || (state == S_FWR);
    fen_waddr = (state == S_CLR) ? clr_cnt : fpm1[ADDR_W-1:0];
    fen_wdata = (state == S_CLR) ? '0 : fen_rdata + fv;
  end

  assign res_valid = (state == S_DONE) && out_free;
  assign res.node  = x;
  assign res.value = sum;

  tpa_ram #(.W(ENTRY_W), .AW(ADDR_W)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (node_addr(item.node_a)),
    .wdata (item.entry),
    .raddr (node_addr(tbl_rnode)),
    .rdata (tbl_rdata)
  );

  tpa_ram #(.W(VAL_W), .AW(ADDR_W)) u_fen (
    .clk   (clk),
    .we    (fen_we),
    .waddr (fen_waddr),
    .wdata (fen_wdata),
    .raddr (fen_raddr),
    .rdata (fen_rdata)
  );

  always_ff @(posedge clk) begin
    ok_q <= node_ok(tbl_rnode);
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x     <= item.node_a;
            y     <= item.node_b;
            steps <= '0;
            z     <= (item.op == OP_DEC) ? (VAL_W'(0) - item.amount) : item.amount;
            unique case (item.op)
              OP_INC, OP_DEC: state <= S_RX;
              OP_QUERY:       state <= S_QT;
              OP_CLEAR: begin
                clr_cnt <= '0;
                state   <= S_CLR;
              end
              default:        state <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(MAX_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_RX: state <= S_RY;
        S_RY: begin
          fx    <= ent.top;
          state <= S_GFY;
        end
        S_GFY: begin
          fy    <= ent.top;
          state <= S_CHK;
        end
        S_CHK: begin
          if (fx == fy) begin
            state <= S_FX;
          end else if (steps >= NODE_W'(MAX_NODES)) begin
            state <= S_IDLE;
          end else begin
            steps <= steps + NODE_W'(1);
            state <= S_RFY;
          end
        end
        S_RFY: begin
          e1    <= ent;
          state <= S_SEL;
        end
        S_SEL: begin
          if (e1.depth < ent.depth) begin
            x    <= y;
            y    <= x;
            fx   <= fy;
            fy   <= fx;
            cp   <= ent.position;
            cpar <= ent.parent;
            fp   <= POS_W'(ent.position);
          end else begin
            cp   <= e1.position;
            cpar <= e1.parent;
            fp   <= POS_W'(e1.position);
          end
          fv    <= z;
          ret   <= S_RX2;
          state <= S_FRD;
        end
        S_RX2: state <= S_ADD2;
        S_ADD2: begin
          fp    <= POS_W'(ent.position) + POS_W'(1);
          fv    <= VAL_W'(0) - z;
          ret   <= S_PAR;
          state <= S_FRD;
        end
        S_PAR: begin
          x     <= cpar;
          state <= S_TOP;
        end
        S_TOP: begin
          fx    <= ent.top;
          state <= S_CHK;
        end
        S_FX: state <= S_FY;
        S_FY: begin
          e1    <= ent;
          state <= S_FSEL;
        end
        S_FSEL: begin
          if (e1.depth > ent.depth) begin
            fp <= POS_W'(ent.position);
            cp <= e1.position;
          end else begin
            fp <= POS_W'(e1.position);
            cp <= ent.position;
          end
          fv    <= z;
          ret   <= S_FLAST;
          state <= S_FRD;
        end
        S_FLAST: begin
          fp    <= POS_W'(cp) + POS_W'(1);
          fv    <= VAL_W'(0) - z;
          ret   <= S_IDLE;
          state <= S_FRD;
        end
        S_FRD: state <= fp_in ? S_FWR : ret;
        S_FWR: begin
          fp    <= fp + lb;
          state <= S_FRD;
        end
        S_QT: state <= S_QP;
        S_QP: begin
          fp    <= qpos;
          sum   <= '0;
          state <= S_SRD;
        end
        S_SRD: state <= (fp == '0) ? S_DONE : S_SACC;
        S_SACC: begin
          sum   <= sum + fen_rdata;
          fp    <= fp - lb;
          state <= S_SRD;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fwr_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FWR |-> fp_in) else $error("fenwick write outside limit");
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free) else $error("result while output full");
  a_clr_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !ready) else $error("ready during clear");
  a_sum_desc: assert property (@(posedge clk) disable iff (rst)
    state == S_SACC |=> fp < $past(fp)) else $error("prefix walk not descending");
endmodule

// ----- sv/tree_path_add_point_query.sv -----
`timescale 1ns / 1ps
// Heavy-light path add / point query over a 1024-node Fenwick store. One word is
// taken at a time; s_axis_tready is high only while the sequencer is idle. A load
// or an unused op leaves the sequencer idle. A query reads the store once per set
// bit of the node's position (at most 10). A path add does two Fenwick updates on
// each chain that it touches, each update of up to 11 steps. Each Fenwick step is
// a read and then a write of the store. A query result waits while the output
// holds an untaken word. After reset and on a clear op the store is zeroed one
// entry a cycle, with tready low until the clear is done.
module tree_path_add_point_query import tpa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // node_a, node_b, amount, entry_top, entry_depth, entry_parent, entry_position
  input  logic [103:0] s_axis_tdata,
  // op
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // queried_node, node_value
  output logic [47:0]  m_axis_tdata
);
  logic [NODE_W-1:0] node_count;
  item_t             item;
  res_t              res;
  logic              start, ready, res_valid, out_free;

  assign item.op             = s_axis_tuser;
  assign item.node_a         = s_axis_tdata[10:0];
  assign item.node_b         = s_axis_tdata[21:11];
  assign item.amount         = s_axis_tdata[53:22];
  assign item.entry.top      = s_axis_tdata[64:54];
  assign item.entry.depth    = s_axis_tdata[75:65];
  assign item.entry.parent   = s_axis_tdata[86:76];
  assign item.entry.position = s_axis_tdata[97:87];

  assign s_axis_tready = ready;
  assign start         = s_axis_tvalid && ready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= NODE_W'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (res_valid) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (res_valid) begin
      m_axis_tdata <= {5'd0, res.value, res.node};
    end
  end

  tpa_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .node_count (node_count),
    .out_free   (out_free),
    .ready      (ready),
    .res_valid  (res_valid),
    .res        (res)
  );
endmodule
